// ===== src/lsfb_pkg.sv =====
// Shared types and constants for the LED strip frame buffer.
`default_nettype none
package lsfb_pkg;

   localparam int IndexW = 6;
   localparam int ColorW = 29;
   localparam int FrameW = 32;

   localparam logic [2:0] FrameTag = 3'b111;

   localparam logic [2:0] ACT_CLEAR   = 3'd0;
   localparam logic [2:0] ACT_SET     = 3'd1;
   localparam logic [2:0] ACT_COMMIT  = 3'd2;
   localparam logic [2:0] ACT_SAVE    = 3'd3;
   localparam logic [2:0] ACT_RESTORE = 3'd4;

   typedef enum logic [2:0] {
      OP_CLEAR,
      OP_SET,
      OP_COMMIT,
      OP_SAVE,
      OP_RESTORE
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [IndexW-1:0]   index;
      logic                slot;
      logic [ColorW-1:0]   color;
   } cmd_type;

endpackage
`default_nettype wire

// ===== src/lsfb_front.sv =====
// Command decode: classify incoming words and drop the ones that do nothing.
`default_nettype none
module lsfb_front #(
   parameter int LED_COUNT = 32
) (
   input  wire logic                 start,
   input  wire logic                 busy,
   input  wire logic [2:0]           req_action,
   input  wire logic [5:0]           req_led_index,
   input  wire logic [1:0]           req_slot,
   input  wire logic [4:0]           req_brightness,
   input  wire logic [7:0]           req_red,
   input  wire logic [7:0]           req_green,
   input  wire logic [7:0]           req_blue,
   output logic                      push,
   output lsfb_pkg::cmd_type         cmd
);
   import lsfb_pkg::*;

   logic keep;

   always_comb begin
      cmd.index = req_led_index;
      cmd.slot  = req_slot[0];
      cmd.color = {req_brightness, req_blue, req_green, req_red};
      cmd.op    = OP_CLEAR;
      keep      = 1'b0;
      unique case (req_action)
         ACT_CLEAR: begin
            cmd.op = OP_CLEAR;
            keep   = 1'b1;
         end
         ACT_SET: begin
            cmd.op = OP_SET;
            keep   = (req_led_index < IndexW'(LED_COUNT));
         end
         ACT_COMMIT: begin
            cmd.op = OP_COMMIT;
            keep   = 1'b1;
         end
         ACT_SAVE: begin
            cmd.op = OP_SAVE;
            keep   = ~req_slot[1];
         end
         ACT_RESTORE: begin
            cmd.op = OP_RESTORE;
            keep   = ~req_slot[1];
         end
         default: begin
            // unknown action: drop
            keep = 1'b0;
         end
      endcase
   end

   assign push = start & ~busy & keep;

endmodule
`default_nettype wire

// ===== src/lsfb_queue.sv =====
// Two-entry command queue between the decoder and the sequencer.
`default_nettype none
module lsfb_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire lsfb_pkg::cmd_type    push_cmd,
   input  wire logic                 pop,
   output lsfb_pkg::cmd_type         head,
   output logic                      empty,
   output logic                      full
);
   import lsfb_pkg::*;

   cmd_type     entry_ff [2];
   logic        wr_ptr_ff;
   logic        rd_ptr_ff;
   logic [1:0]  count_ff;
   logic        wr_ptr_in;
   logic        rd_ptr_in;
   logic [1:0]  count_in;

   assign empty = (count_ff == 2'd0);
   assign full  = (count_ff == 2'd2);
   assign head  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule
`default_nettype wire

// ===== src/lsfb_back.sv =====
// Sequencer: color store, snapshot banks and frame emission.
`default_nettype none
module lsfb_back #(
   parameter int LED_COUNT = 32
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire lsfb_pkg::cmd_type    head,
   input  wire logic                 empty,
   output logic                      pop,
   output logic                      rsp_valid,
   output logic [31:0]               rsp_frame,
   output logic                      rsp_last
);
   import lsfb_pkg::*;

   localparam int IdxW      = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
   localparam int SnapDepth = 2 * LED_COUNT;
   localparam int SnapW     = $clog2(SnapDepth);
   localparam int PadFrames = (LED_COUNT + 63) / 64;
   localparam int TailW     = $clog2(PadFrames + 2);
   localparam logic [IdxW-1:0]  LastIdx  = IdxW'(LED_COUNT - 1);
   localparam logic [TailW-1:0] LastTail = TailW'(PadFrames);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COMMIT,
      ST_TAIL,
      ST_COPY
   } state_type;

   state_type               state_ff, state_in;
   logic [IdxW-1:0]         cnt_ff, cnt_in;
   logic [TailW-1:0]        tail_ff, tail_in;
   logic                    save_ff, save_in;
   logic                    slot_ff, slot_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [FrameW-1:0]       rsp_frame_ff, rsp_frame_in;
   logic                    rsp_last_ff, rsp_last_in;
   logic [LED_COUNT-1:0]    color_valid_ff, color_valid_in;
   logic [SnapDepth-1:0]    snap_valid_ff, snap_valid_in;

   logic [ColorW-1:0]       color_mem [LED_COUNT];
   logic [ColorW-1:0]       snap_mem [SnapDepth];
   logic [ColorW-1:0]       color_rdata_ff;
   logic                    color_rvalid_ff;
   logic [ColorW-1:0]       snap_rdata_ff;
   logic                    snap_rvalid_ff;

   logic                    color_we;
   logic [IdxW-1:0]         color_waddr;
   logic [ColorW-1:0]       color_wdata;
   logic [IdxW-1:0]         color_raddr;
   logic                    snap_we;
   logic [SnapW-1:0]        snap_waddr;
   logic [ColorW-1:0]       snap_wdata;
   logic [SnapW-1:0]        snap_raddr;
   logic [IdxW-1:0]         cnt_next;
   logic [ColorW-1:0]       color_src;
   logic [ColorW-1:0]       snap_src;

   function automatic logic [SnapW-1:0] snap_addr(input logic bank,
                                                  input logic [IdxW-1:0] idx);
      logic [SnapW-1:0] base;
      base = SnapW'(idx);
      return bank ? base + SnapW'(LED_COUNT) : base;
   endfunction

   assign color_src = color_rvalid_ff ? color_rdata_ff : '0;
   assign snap_src  = snap_rvalid_ff ? snap_rdata_ff : '0;
   // stay in range on the final entry
   assign cnt_next  = (cnt_ff == LastIdx) ? '0 : cnt_ff + 1'b1;

   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      tail_in        = tail_ff;
      save_in        = save_ff;
      slot_in        = slot_ff;
      rsp_valid_in   = 1'b0;
      rsp_frame_in   = '0;
      rsp_last_in    = 1'b0;
      color_valid_in = color_valid_ff;
      snap_valid_in  = snap_valid_ff;
      pop            = 1'b0;
      color_we       = 1'b0;
      color_waddr    = cnt_ff;
      color_wdata    = snap_src;
      color_raddr    = cnt_next;
      snap_we        = 1'b0;
      snap_waddr     = snap_addr(slot_ff, cnt_ff);
      snap_wdata     = color_src;
      snap_raddr     = snap_addr(slot_ff, cnt_next);

      unique case (state_ff)
         ST_IDLE: begin
            if (!empty) begin
               pop     = 1'b1;
               cnt_in  = '0;
               slot_in = head.slot;
               unique case (head.op)
                  OP_CLEAR: begin
                     color_valid_in = '0;
                  end
                  OP_SET: begin
                     color_we                    = 1'b1;
                     color_waddr                 = head.index[IdxW-1:0];
                     color_wdata                 = head.color;
                     color_valid_in[color_waddr] = 1'b1;
                  end
                  OP_COMMIT: begin
                     // start frame now, first entry read in flight
                     rsp_valid_in = 1'b1;
                     color_raddr  = '0;
                     state_in     = ST_COMMIT;
                  end
                  OP_SAVE: begin
                     color_raddr = '0;
                     save_in     = 1'b1;
                     state_in    = ST_COPY;
                  end
                  OP_RESTORE: begin
                     snap_raddr = snap_addr(head.slot, '0);
                     save_in    = 1'b0;
                     state_in   = ST_COPY;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_COMMIT: begin
            rsp_valid_in = 1'b1;
            rsp_frame_in = {FrameTag, color_src};
            cnt_in       = cnt_next;
            if (cnt_ff == LastIdx) begin
               tail_in  = '0;
               state_in = ST_TAIL;
            end
         end
         ST_TAIL: begin
            // end frame, then padding; mark the final one
            rsp_valid_in = 1'b1;
            rsp_last_in  = (tail_ff == LastTail);
            tail_in      = tail_ff + 1'b1;
            if (tail_ff == LastTail) begin
               state_in = ST_IDLE;
            end
         end
         ST_COPY: begin
            if (save_ff) begin
               snap_we                   = 1'b1;
               snap_valid_in[snap_waddr] = 1'b1;
            end else begin
               color_we                    = 1'b1;
               color_valid_in[color_waddr] = 1'b1;
            end
            cnt_in = cnt_next;
            if (cnt_ff == LastIdx) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         color_valid_ff <= '0;
         snap_valid_ff  <= '0;
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         color_valid_ff <= color_valid_in;
         snap_valid_ff  <= snap_valid_in;
      end
      cnt_ff       <= cnt_in;
      tail_ff      <= tail_in;
      save_ff      <= save_in;
      slot_ff      <= slot_in;
      rsp_frame_ff <= rsp_frame_in;
      rsp_last_ff  <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (color_we) begin
         color_mem[color_waddr] <= color_wdata;
      end
      color_rdata_ff  <= color_mem[color_raddr];
      color_rvalid_ff <= color_valid_ff[color_raddr];
   end

   always_ff @(posedge clock) begin
      if (snap_we) begin
         snap_mem[snap_waddr] <= snap_wdata;
      end
      snap_rdata_ff  <= snap_mem[snap_raddr];
      snap_rvalid_ff <= snap_valid_ff[snap_raddr];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_frame = rsp_frame_ff;
   assign rsp_last  = rsp_last_ff;

endmodule
`default_nettype wire

// ===== src/led_strip_frame_buffer.sv =====
// Top level of the LED strip frame buffer.
//
// Commands enter on the req_ ports and are taken on a clock edge with start
// high and busy low. A decoder drops commands that do nothing (set with an
// index of LED_COUNT or more, save or restore to bank 2 or 3, unknown
// actions) and queues the rest in a two-entry queue; busy is high while that
// queue is full. A sequencer works off one queued command at a time: clear
// and set act on the color store, save and restore copy one entry per cycle
// between the color store and a snapshot bank, and commit emits a frame.
// The color store and the snapshot store that holds both banks each have one
// read port, so commit and copy move one entry per cycle. Commit output
// starts in the cycle after the command leaves the queue: a zero start word,
// one word per LED, a zero end word and ceil(LED_COUNT/64) zero padding
// words, back to back, rsp_valid high for one cycle per word and rsp_last on
// the final one. The receiver cannot stall the output. Reset empties the
// queue, idles the sequencer and clears every store's valid flags to zero.
`default_nettype none
module led_strip_frame_buffer #(
   parameter int LED_COUNT = 32
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   output logic               busy,
   input  wire logic [2:0]    req_action,
   input  wire logic [5:0]    req_led_index,
   input  wire logic [1:0]    req_slot,
   input  wire logic [4:0]    req_brightness,
   input  wire logic [7:0]    req_red,
   input  wire logic [7:0]    req_green,
   input  wire logic [7:0]    req_blue,
   output logic               rsp_valid,
   output logic [31:0]        rsp_frame,
   output logic               rsp_last
);
   import lsfb_pkg::*;

   logic    push;
   cmd_type push_cmd;
   cmd_type head;
   logic    pop;
   logic    empty;
   logic    full;

   assign busy = full;

   lsfb_front #(
      .LED_COUNT (LED_COUNT)
   ) u_front (
      .start          (start),
      .busy           (busy),
      .req_action     (req_action),
      .req_led_index  (req_led_index),
      .req_slot       (req_slot),
      .req_brightness (req_brightness),
      .req_red        (req_red),
      .req_green      (req_green),
      .req_blue       (req_blue),
      .push           (push),
      .cmd            (push_cmd)
   );

   lsfb_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (head),
      .empty    (empty),
      .full     (full)
   );

   lsfb_back #(
      .LED_COUNT (LED_COUNT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .empty     (empty),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_frame (rsp_frame),
      .rsp_last  (rsp_last)
   );

endmodule
`default_nettype wire
